FILE: src/lobm_pkg.sv
// Package for the limit order book matcher.
// Holds the operation, status and record-kind codes; depends on nothing.
package lobm_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic SIDE_BID = 1'b0;

endpackage

FILE: src/lobm_slot_mem.sv
// Order slot storage: id, side, price, remaining quantity and arrival sequence.
// One write port (whole record or remaining only), one registered read port; uses no package.
module lobm_slot_mem #(
  parameter int SLOTS = 32,
  parameter int PRICE_BITS = 16,
  parameter int IDX = 5
) (
  input  logic                  clk,
  input  logic                  we_rec,
  input  logic                  we_rem,
  input  logic [IDX-1:0]        waddr,
  input  logic [31:0]           wr_id,
  input  logic                  wr_side,
  input  logic [PRICE_BITS-1:0] wr_price,
  input  logic [31:0]           wr_rem,
  input  logic [31:0]           wr_seq,
  input  logic                  re,
  input  logic [IDX-1:0]        raddr,
  output logic [31:0]           rd_id,
  output logic                  rd_side,
  output logic [PRICE_BITS-1:0] rd_price,
  output logic [31:0]           rd_rem,
  output logic [31:0]           rd_seq
);

  logic [31:0]           id_mem    [SLOTS];
  logic                  side_mem  [SLOTS];
  logic [PRICE_BITS-1:0] price_mem [SLOTS];
  logic [31:0]           rem_mem   [SLOTS];
  logic [31:0]           seq_mem   [SLOTS];

  always_ff @(posedge clk) begin
    if (we_rec) begin
      id_mem[waddr]    <= wr_id;
      side_mem[waddr]  <= wr_side;
      price_mem[waddr] <= wr_price;
      seq_mem[waddr]   <= wr_seq;
    end
    if (we_rec || we_rem) begin
      rem_mem[waddr] <= wr_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_id    <= id_mem[raddr];
      rd_side  <= side_mem[raddr];
      rd_price <= price_mem[raddr];
      rd_rem   <= rem_mem[raddr];
      rd_seq   <= seq_mem[raddr];
    end
  end

endmodule

FILE: src/lobm_rank.sv
// Shared price-time rank compare used during the best-order scan.
// Decides whether a slot beats the current best on its own side; uses lobm_pkg.
module lobm_rank #(
  parameter int PRICE_BITS = 16
) (
  input  logic                  side,
  input  logic [PRICE_BITS-1:0] price,
  input  logic [31:0]           age,
  input  logic                  best_have,
  input  logic [PRICE_BITS-1:0] best_price,
  input  logic [31:0]           best_age,
  output logic                  take
);

  logic better_price;

  always_comb begin
    if (side == lobm_pkg::SIDE_BID) begin
      better_price = price > best_price;
    end else begin
      better_price = price < best_price;
    end
    if (!best_have) begin
      take = 1'b1;
    end else if (price != best_price) begin
      take = better_price;
    end else begin
      take = age > best_age;
    end
  end

endmodule

FILE: src/limit_order_book_matcher.sv
// Top level of the limit order book matcher: sequencer, valid bits and result register.
// Uses lobm_pkg, lobm_slot_mem and lobm_rank.
//
//   Channel  Ports                                   Transfer
//   input    start, busy, in_*                       start high while busy low
//   result   out_valid, out_*                        one-cycle strobe, no stall
//
// A request is taken when start is high while busy is low and is then scanned over
// the slots by one shared read port and one rank compare. A cancel costs one id scan;
// an add costs one id scan, the S_WRITE state and then one best-order scan per trade
// plus one final scan, each trade passing S_TRADE and S_TRADE2 for the remaining-
// quantity write-backs; the done result comes from S_DONE. Reset empties the book at once
// (valid bits only) and clears the arrival counter. Results cannot be held off, so
// the sequencer never waits on the receiver.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 32,
  parameter int PRICE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic [15:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  output logic        out_kind,
  output logic [31:0] out_bid_order_id,
  output logic [15:0] out_bid_price,
  output logic [31:0] out_ask_order_id,
  output logic [15:0] out_ask_price,
  output logic [31:0] out_fill_quantity,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int IDX = $clog2(ORDER_SLOTS);
  localparam int CNT = $clog2(ORDER_SLOTS + 1);
  localparam logic [CNT-1:0] LAST_CNT = CNT'(ORDER_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_IDSCAN, S_WRITE, S_MSCAN, S_TRADE, S_TRADE2, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Request fields.
  logic [1:0]            func_r, func_nxt;
  logic [31:0]           oid_r, oid_nxt;
  logic                  side_r, side_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [31:0]           qty_r, qty_nxt;

  logic [ORDER_SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0]            ctr_r, ctr_nxt;
  logic [1:0]             status_r, status_nxt;

  // Scan control: cnt_r issues addresses, pend_r/pidx_r track the slot whose data is back.
  logic [CNT-1:0] cnt_r, cnt_nxt;
  logic           pend_r, pend_nxt;
  logic [IDX-1:0] pidx_r, pidx_nxt;

  // Id scan results.
  logic           found_r, found_nxt;
  logic [IDX-1:0] match_r, match_nxt;
  logic           free_r, free_nxt;
  logic [IDX-1:0] fidx_r, fidx_nxt;

  // Best bid and best ask seen so far.
  logic                  bb_have_r, bb_have_nxt, ba_have_r, ba_have_nxt;
  logic [IDX-1:0]        bb_idx_r, bb_idx_nxt, ba_idx_r, ba_idx_nxt;
  logic [31:0]           bb_id_r, bb_id_nxt, ba_id_r, ba_id_nxt;
  logic [PRICE_BITS-1:0] bb_price_r, bb_price_nxt, ba_price_r, ba_price_nxt;
  logic [31:0]           bb_rem_r, bb_rem_nxt, ba_rem_r, ba_rem_nxt;
  logic [31:0]           bb_age_r, bb_age_nxt, ba_age_r, ba_age_nxt;

  // Result register.
  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  logic [31:0] obid_r, obid_nxt, oask_r, oask_nxt, oqty_r, oqty_nxt;
  logic [15:0] obp_r, obp_nxt, oap_r, oap_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        olast_r, olast_nxt;

  // Memory port.
  logic                  we_rec, we_rem, re;
  logic [IDX-1:0]        waddr, raddr;
  logic [31:0]           wr_rem;
  logic [31:0]           rd_id, rd_rem, rd_seq;
  logic                  rd_side;
  logic [PRICE_BITS-1:0] rd_price;

  // Shared rank unit.
  logic                  rk_have, rk_take;
  logic [PRICE_BITS-1:0] rk_price;
  logic [31:0]           rk_age, age;

  logic [31:0]    in_price_ext, bp_ext, ap_ext, q, bid_left, ask_left;
  logic [IDX-1:0] new_slot;
  logic           scan_end, slot_ok;

  lobm_slot_mem #(.SLOTS(ORDER_SLOTS), .PRICE_BITS(PRICE_BITS), .IDX(IDX)) u_mem (
    .clk      (clk),
    .we_rec   (we_rec),
    .we_rem   (we_rem),
    .waddr    (waddr),
    .wr_id    (oid_r),
    .wr_side  (side_r),
    .wr_price (price_r),
    .wr_rem   (wr_rem),
    .wr_seq   (ctr_r),
    .re       (re),
    .raddr    (raddr),
    .rd_id    (rd_id),
    .rd_side  (rd_side),
    .rd_price (rd_price),
    .rd_rem   (rd_rem),
    .rd_seq   (rd_seq)
  );

  lobm_rank #(.PRICE_BITS(PRICE_BITS)) u_rank (
    .side       (rd_side),
    .price      (rd_price),
    .age        (age),
    .best_have  (rk_have),
    .best_price (rk_price),
    .best_age   (rk_age),
    .take       (rk_take)
  );

  always_comb begin
    age      = ctr_r - rd_seq;
    rk_have  = (rd_side == lobm_pkg::SIDE_BID) ? bb_have_r : ba_have_r;
    rk_price = (rd_side == lobm_pkg::SIDE_BID) ? bb_price_r : ba_price_r;
    rk_age   = (rd_side == lobm_pkg::SIDE_BID) ? bb_age_r : ba_age_r;

    in_price_ext = {16'd0, in_price};
    bp_ext   = 32'(bb_price_r);
    ap_ext   = 32'(ba_price_r);
    q        = (bb_rem_r < ba_rem_r) ? bb_rem_r : ba_rem_r;
    bid_left = bb_rem_r - q;
    ask_left = ba_rem_r - q;
    scan_end = (cnt_r == LAST_CNT) && !pend_r;
    slot_ok  = pend_r && valid_r[pidx_r];

    // A modify may reuse its own freed slot unless a lower one is free.
    if (func_r == lobm_pkg::FUNC_MODIFY && (!free_r || match_r < fidx_r)) begin
      new_slot = match_r;
    end else begin
      new_slot = fidx_r;
    end

    re     = 1'b0;
    raddr  = cnt_r[IDX-1:0];
    we_rec = 1'b0;
    we_rem = 1'b0;
    waddr  = new_slot;
    wr_rem = qty_r;

    state_nxt = state_r;
    func_nxt = func_r; oid_nxt = oid_r; side_nxt = side_r;
    price_nxt = price_r; qty_nxt = qty_r;
    valid_nxt = valid_r; ctr_nxt = ctr_r; status_nxt = status_r;
    cnt_nxt = cnt_r; pend_nxt = pend_r; pidx_nxt = pidx_r;
    found_nxt = found_r; match_nxt = match_r; free_nxt = free_r; fidx_nxt = fidx_r;
    bb_have_nxt = bb_have_r; bb_idx_nxt = bb_idx_r; bb_id_nxt = bb_id_r;
    bb_price_nxt = bb_price_r; bb_rem_nxt = bb_rem_r; bb_age_nxt = bb_age_r;
    ba_have_nxt = ba_have_r; ba_idx_nxt = ba_idx_r; ba_id_nxt = ba_id_r;
    ba_price_nxt = ba_price_r; ba_rem_nxt = ba_rem_r; ba_age_nxt = ba_age_r;
    ov_nxt = 1'b0; okind_nxt = okind_r; obid_nxt = obid_r; obp_nxt = obp_r;
    oask_nxt = oask_r; oap_nxt = oap_r; oqty_nxt = oqty_r; ost_nxt = ost_r;
    olast_nxt = olast_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          oid_nxt   = in_order_id;
          side_nxt  = in_side;
          price_nxt = in_price_ext[PRICE_BITS-1:0];
          qty_nxt   = in_quantity;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          status_nxt = lobm_pkg::ST_OK;
          if (in_func == lobm_pkg::FUNC_ADD || in_func == lobm_pkg::FUNC_CANCEL ||
              in_func == lobm_pkg::FUNC_MODIFY) begin
            state_nxt = S_IDSCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_IDSCAN: begin
        re       = cnt_r != LAST_CNT;
        pend_nxt = cnt_r != LAST_CNT;
        pidx_nxt = cnt_r[IDX-1:0];
        if (cnt_r != LAST_CNT) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (slot_ok && rd_id == oid_r) begin
          found_nxt = 1'b1;
          match_nxt = pidx_r;
        end
        if (pend_r && !valid_r[pidx_r] && !free_r) begin
          free_nxt = 1'b1;
          fidx_nxt = pidx_r;
        end
        if (scan_end) begin
          state_nxt = S_DONE;
          if (func_r == lobm_pkg::FUNC_ADD) begin
            if (found_r) begin
              status_nxt = lobm_pkg::ST_DUP;
            end else if (qty_r == 32'd0) begin
              status_nxt = lobm_pkg::ST_OK;
            end else if (!free_r) begin
              status_nxt = lobm_pkg::ST_FULL;
            end else begin
              state_nxt = S_WRITE;
            end
          end else if (!found_r) begin
            status_nxt = lobm_pkg::ST_UNKNOWN;
          end else begin
            valid_nxt[match_r] = 1'b0;
            if (func_r == lobm_pkg::FUNC_MODIFY && qty_r != 32'd0) begin
              state_nxt = S_WRITE;
            end
          end
        end
      end
      S_WRITE: begin
        we_rec = 1'b1;
        valid_nxt[new_slot] = 1'b1;
        ctr_nxt = ctr_r + 32'd1;
        cnt_nxt = '0;
        pend_nxt = 1'b0;
        bb_have_nxt = 1'b0;
        ba_have_nxt = 1'b0;
        state_nxt = S_MSCAN;
      end
      S_MSCAN: begin
        re       = cnt_r != LAST_CNT;
        pend_nxt = cnt_r != LAST_CNT;
        pidx_nxt = cnt_r[IDX-1:0];
        if (cnt_r != LAST_CNT) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (slot_ok && rk_take) begin
          if (rd_side == lobm_pkg::SIDE_BID) begin
            bb_have_nxt = 1'b1; bb_idx_nxt = pidx_r; bb_id_nxt = rd_id;
            bb_price_nxt = rd_price; bb_rem_nxt = rd_rem; bb_age_nxt = age;
          end else begin
            ba_have_nxt = 1'b1; ba_idx_nxt = pidx_r; ba_id_nxt = rd_id;
            ba_price_nxt = rd_price; ba_rem_nxt = rd_rem; ba_age_nxt = age;
          end
        end
        if (scan_end) begin
          if (bb_have_r && ba_have_r && bb_price_r >= ba_price_r) begin
            state_nxt = S_TRADE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_TRADE: begin
        ov_nxt    = 1'b1;
        okind_nxt = lobm_pkg::KIND_TRADE;
        obid_nxt  = bb_id_r;
        obp_nxt   = bp_ext[15:0];
        oask_nxt  = ba_id_r;
        oap_nxt   = ap_ext[15:0];
        oqty_nxt  = q;
        ost_nxt   = lobm_pkg::ST_OK;
        olast_nxt = 1'b0;
        we_rem    = 1'b1;
        waddr     = bb_idx_r;
        wr_rem    = bid_left;
        ba_rem_nxt = ask_left;
        if (bid_left == 32'd0) begin
          valid_nxt[bb_idx_r] = 1'b0;
        end
        if (ask_left == 32'd0) begin
          valid_nxt[ba_idx_r] = 1'b0;
        end
        state_nxt = S_TRADE2;
      end
      S_TRADE2: begin
        we_rem = 1'b1;
        waddr  = ba_idx_r;
        wr_rem = ba_rem_r;
        cnt_nxt = '0;
        pend_nxt = 1'b0;
        bb_have_nxt = 1'b0;
        ba_have_nxt = 1'b0;
        state_nxt = S_MSCAN;
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        okind_nxt = lobm_pkg::KIND_DONE;
        obid_nxt  = 32'd0;
        obp_nxt   = 16'd0;
        oask_nxt  = 32'd0;
        oap_nxt   = 16'd0;
        oqty_nxt  = 32'd0;
        ost_nxt   = status_r;
        olast_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ctr_r   <= 32'd0;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ctr_r   <= ctr_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
    func_r <= func_nxt; oid_r <= oid_nxt; side_r <= side_nxt;
    price_r <= price_nxt; qty_r <= qty_nxt; status_r <= status_nxt;
    pidx_r <= pidx_nxt;
    found_r <= found_nxt; match_r <= match_nxt; free_r <= free_nxt; fidx_r <= fidx_nxt;
    bb_have_r <= bb_have_nxt; bb_idx_r <= bb_idx_nxt; bb_id_r <= bb_id_nxt;
    bb_price_r <= bb_price_nxt; bb_rem_r <= bb_rem_nxt; bb_age_r <= bb_age_nxt;
    ba_have_r <= ba_have_nxt; ba_idx_r <= ba_idx_nxt; ba_id_r <= ba_id_nxt;
    ba_price_r <= ba_price_nxt; ba_rem_r <= ba_rem_nxt; ba_age_r <= ba_age_nxt;
    okind_r <= okind_nxt; obid_r <= obid_nxt; obp_r <= obp_nxt;
    oask_r <= oask_nxt; oap_r <= oap_nxt; oqty_r <= oqty_nxt;
    ost_r <= ost_nxt; olast_r <= olast_nxt;
  end

  assign busy              = state_r != S_IDLE;
  assign out_valid         = ov_r;
  assign out_kind          = okind_r;
  assign out_bid_order_id  = obid_r;
  assign out_bid_price     = obp_r;
  assign out_ask_order_id  = oask_r;
  assign out_ask_price     = oap_r;
  assign out_fill_quantity = oqty_r;
  assign out_status        = ost_r;
  assign out_last          = olast_r;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for limit_order_book_matcher: directed table, book fill, then random requests.
// Depends on lobm_pkg and the matcher RTL; the book behavior is predicted in-line.
module tb;

  localparam int SLOTS = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int EXP_DEPTH = 128;
  localparam int ROW_DEPTH = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = lobm_pkg::FUNC_ADD;
  logic [31:0] in_order_id = '0;
  logic        in_side = lobm_pkg::SIDE_BID;
  logic [15:0] in_price = '0;
  logic [31:0] in_quantity = '0;
  logic        out_valid;
  logic        out_kind;
  logic [31:0] out_bid_order_id;
  logic [15:0] out_bid_price;
  logic [31:0] out_ask_order_id;
  logic [15:0] out_ask_price;
  logic [31:0] out_fill_quantity;
  logic [1:0]  out_status;
  logic        out_last;

  limit_order_book_matcher u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_order_id(in_order_id), .in_side(in_side),
    .in_price(in_price), .in_quantity(in_quantity),
    .out_valid(out_valid), .out_kind(out_kind),
    .out_bid_order_id(out_bid_order_id), .out_bid_price(out_bid_price),
    .out_ask_order_id(out_ask_order_id), .out_ask_price(out_ask_price),
    .out_fill_quantity(out_fill_quantity), .out_status(out_status), .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic        kind;
    logic [31:0] bid_id;
    logic [15:0] bid_price;
    logic [31:0] ask_id;
    logic [15:0] ask_price;
    logic [31:0] fill_qty;
    logic [1:0]  status;
    logic        last;
  } book_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] id;
    logic        side;
    logic [15:0] price;
    logic [31:0] qty;
    bit          typed;      // expected done status is written into the row
    logic [1:0]  exp_status;
  } order_req_t;

  // Expected results, oldest first, kept in a ring.
  book_result_t exp_store[EXP_DEPTH];
  int exp_head = 0;
  int exp_tail = 0;

  order_req_t directed_reqs[ROW_DEPTH];
  int n_directed = 0;
  int errors = 0;
  int idle_cycles = 0;

  // Shadow copy of the book.
  bit          bk_valid[SLOTS];
  logic [31:0] bk_id[SLOTS];
  logic        bk_side[SLOTS];
  logic [15:0] bk_price[SLOTS];
  logic [31:0] bk_remain[SLOTS];
  logic [31:0] bk_seq[SLOTS];
  logic [31:0] bk_arrivals;

  function automatic void exp_append(book_result_t t);
    exp_store[exp_tail % EXP_DEPTH] = t;
    exp_tail++;
  endfunction

  function automatic book_result_t exp_next();
    book_result_t t;
    t = exp_store[exp_head % EXP_DEPTH];
    exp_head++;
    return t;
  endfunction

  function automatic int exp_count();
    return exp_tail - exp_head;
  endfunction

  function automatic void add_row(order_req_t r);
    directed_reqs[n_directed] = r;
    n_directed++;
  endfunction

  function automatic int lookup_id(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // Best price on one side; among equal prices the oldest arrival, then the lower slot.
  function automatic int best_on_side(logic sd);
    int best;
    logic [31:0] age_i, age_b;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_valid[i] || bk_side[i] != sd) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (bk_price[i] != bk_price[best]) begin
        if (sd == lobm_pkg::SIDE_BID ? bk_price[i] > bk_price[best]
                                     : bk_price[i] < bk_price[best])
          best = i;
        continue;
      end
      age_i = bk_arrivals - bk_seq[i];
      age_b = bk_arrivals - bk_seq[best];
      if (age_i > age_b) best = i;
    end
    return best;
  endfunction

  // Rests an order and queues one expected trade per fill; returns the done status.
  function automatic logic [1:0] rest_and_match(order_req_t r);
    int slot, b, a, trades;
    logic [31:0] q;
    book_result_t t;
    slot = -1;
    trades = 0;
    if (lookup_id(r.id) >= 0) return lobm_pkg::ST_DUP;
    if (r.qty == 0) return lobm_pkg::ST_OK;
    for (int i = 0; i < SLOTS; i++)
      if (!bk_valid[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return lobm_pkg::ST_FULL;
    bk_valid[slot] = 1'b1;
    bk_id[slot] = r.id;
    bk_side[slot] = r.side;
    bk_price[slot] = r.price;
    bk_remain[slot] = r.qty;
    bk_seq[slot] = bk_arrivals;
    bk_arrivals = bk_arrivals + 1;
    while (trades < SLOTS) begin
      b = best_on_side(lobm_pkg::SIDE_BID);
      a = best_on_side(~lobm_pkg::SIDE_BID);
      if (b < 0 || a < 0 || bk_price[b] < bk_price[a]) break;
      q = bk_remain[b] < bk_remain[a] ? bk_remain[b] : bk_remain[a];
      bk_remain[b] -= q;
      bk_remain[a] -= q;
      t = '{lobm_pkg::KIND_TRADE, bk_id[b], bk_price[b], bk_id[a], bk_price[a], q,
            lobm_pkg::ST_OK, 1'b0};
      exp_append(t);
      trades++;
      if (bk_remain[b] == 0) bk_valid[b] = 1'b0;
      if (bk_remain[a] == 0) bk_valid[a] = 1'b0;
    end
    return lobm_pkg::ST_OK;
  endfunction

  // Applies one accepted request to the shadow book and queues what it must produce.
  function automatic logic [1:0] apply_request(order_req_t r);
    logic [1:0] st;
    int s;
    book_result_t d;
    st = lobm_pkg::ST_OK;
    if (r.func == lobm_pkg::FUNC_ADD) begin
      st = rest_and_match(r);
    end else if (r.func == lobm_pkg::FUNC_CANCEL || r.func == lobm_pkg::FUNC_MODIFY) begin
      s = lookup_id(r.id);
      if (s < 0) begin
        st = lobm_pkg::ST_UNKNOWN;
      end else begin
        bk_valid[s] = 1'b0;
        if (r.func == lobm_pkg::FUNC_MODIFY) st = rest_and_match(r);
      end
    end
    d = '{lobm_pkg::KIND_DONE, '0, '0, '0, '0, '0, st, 1'b1};
    exp_append(d);
    return st;
  endfunction

  function automatic order_req_t mk(logic [1:0] f, logic [31:0] id, logic sd,
                                    logic [15:0] pr, logic [31:0] q, bit typed,
                                    logic [1:0] st);
    order_req_t r;
    r = '{f, id, sd, pr, q, typed, st};
    return r;
  endfunction

  // Random request: mostly ids from a small pool so that cancels and modifies hit,
  // prices clustered so that the book crosses, and now and then the full field range.
  function automatic order_req_t random_request();
    order_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 48) r.func = lobm_pkg::FUNC_ADD;
    else if (pick < 70) r.func = lobm_pkg::FUNC_CANCEL;
    else if (pick < 95) r.func = lobm_pkg::FUNC_MODIFY;
    else r.func = lobm_pkg::FUNC_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 75) r.id = $urandom_range(0, 47);
    else if (pick < 90) r.id = $urandom_range(100, 147);
    else r.id = $urandom;
    r.side = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 85) r.price = 16'(32'd992 + $urandom_range(0, 16));
    else r.price = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) r.qty = $urandom_range(1, 40);
    else if (pick < 92) r.qty = $urandom;
    else r.qty = '0;
    r.typed = 1'b0;
    r.exp_status = lobm_pkg::ST_OK;
    return r;
  endfunction

  // Result checker: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    book_result_t e;
    if (rst_n && out_valid) begin
      if (exp_count() == 0) begin
        $error("result with nothing expected: kind %0d status %0d", out_kind, out_status);
        errors++;
      end else begin
        e = exp_next();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0h, got %0h", e.kind, out_kind); errors++;
        end
        if (out_bid_order_id !== e.bid_id) begin
          $error("bid_order_id: expected %0h, got %0h", e.bid_id, out_bid_order_id); errors++;
        end
        if (out_bid_price !== e.bid_price) begin
          $error("bid_price: expected %0h, got %0h", e.bid_price, out_bid_price); errors++;
        end
        if (out_ask_order_id !== e.ask_id) begin
          $error("ask_order_id: expected %0h, got %0h", e.ask_id, out_ask_order_id); errors++;
        end
        if (out_ask_price !== e.ask_price) begin
          $error("ask_price: expected %0h, got %0h", e.ask_price, out_ask_price); errors++;
        end
        if (out_fill_quantity !== e.fill_qty) begin
          $error("fill_quantity: expected %0h, got %0h", e.fill_qty, out_fill_quantity);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0h, got %0h", e.status, out_status); errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0h, got %0h", e.last, out_last); errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result is accepted.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drives one request and waits for the edge that accepts it. start is left high so a
  // following request in the same burst goes out without a dead cycle.
  task automatic send_request(order_req_t r);
    logic [1:0] st;
    start <= 1'b1;
    in_func <= r.func;
    in_order_id <= r.id;
    in_side <= r.side;
    in_price <= r.price;
    in_quantity <= r.qty;
    @(posedge clk);
    while (busy) @(posedge clk);
    st = apply_request(r);
    if (r.typed && st !== r.exp_status) begin
      $error("status: expected %0h, got %0h (table row vs book)", r.exp_status, st);
      errors++;
    end
  endtask

  int burst_left = 0;

  // Sender bursts: at the end of a burst start drops for a random gap.
  task automatic pace_sender();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 5);
    end
    burst_left--;
  endtask

  initial begin
    order_req_t r;
    for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
    bk_arrivals = '0;

    // Directed table: empty-book misses, unused code, extremes, duplicate id,
    // zero quantity, loss of time priority on modify, modify to zero as cancel.
    add_row(mk(lobm_pkg::FUNC_CANCEL, 32'd5, 1'b0, 16'd0, 32'd0, 1'b1, lobm_pkg::ST_UNKNOWN));
    add_row(mk(lobm_pkg::FUNC_MODIFY, 32'd5, 1'b1, 16'd9, 32'd3, 1'b1, lobm_pkg::ST_UNKNOWN));
    add_row(mk(lobm_pkg::FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
               lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
               lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd0, 1'b1, 16'd0, 32'd1, 1'b1, lobm_pkg::ST_DUP));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 16'd0, 32'd1, 1'b1,
               lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd7, 1'b1, 16'd0, 32'hFFFF_FFFE, 1'b1,
               lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd8, 1'b0, 16'd0, 32'd0, 1'b1, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_CANCEL, 32'd8, 1'b0, 16'd0, 32'd0, 1'b1, lobm_pkg::ST_UNKNOWN));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd9, 1'b0, 16'd100, 32'd10, 1'b0, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd10, 1'b0, 16'd100, 32'd10, 1'b0, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_MODIFY, 32'd9, 1'b0, 16'd100, 32'd10, 1'b0, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd11, 1'b1, 16'd90, 32'd15, 1'b0, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd12, 1'b1, 16'd200, 32'd3, 1'b0, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_MODIFY, 32'd12, 1'b1, 16'd200, 32'd0, 1'b0, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_CANCEL, 32'd9, 1'b0, 16'd0, 32'd0, 1'b1, lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_CANCEL, 32'd9, 1'b0, 16'd0, 32'd0, 1'b1, lobm_pkg::ST_UNKNOWN));
    // Fill every slot with non-crossing bids, then overflow; a modify on a full book
    // frees its own slot first and so still succeeds.
    for (int i = 0; i < SLOTS; i++)
      add_row(mk(lobm_pkg::FUNC_ADD, 32'd100 + i, 1'b0, 16'd50, 32'd1, 1'b0,
                 lobm_pkg::ST_OK));
    add_row(mk(lobm_pkg::FUNC_ADD, 32'd132, 1'b1, 16'd900, 32'd1, 1'b1, lobm_pkg::ST_FULL));
    add_row(mk(lobm_pkg::FUNC_MODIFY, 32'd100, 1'b0, 16'd60, 32'd2, 1'b1, lobm_pkg::ST_OK));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < n_directed; k++) begin
      pace_sender();
      send_request(directed_reqs[k]);
    end

    for (int n = 0; n < 330; n++) begin
      // Hold off once until the book has answered everything sent so far.
      if (n == 165) begin
        start <= 1'b0;
        burst_left = 0;
        while (exp_count() != 0) @(posedge clk);
      end
      r = random_request();
      pace_sender();
      send_request(r);
    end
    start <= 1'b0;

    while (exp_count() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && exp_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lobm_pkg.sv
src/lobm_slot_mem.sv
src/lobm_rank.sv
src/limit_order_book_matcher.sv
tb/sv/tb.sv
